// ----- hw/rtl/vector_row_convolver_truncated_defines.svh -----
// Assertion macros used by the checker file of the row convolver.
`ifndef VECTOR_ROW_CONVOLVER_TRUNCATED_DEFINES_SVH
`define VECTOR_ROW_CONVOLVER_TRUNCATED_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define VRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define VRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vrc_pkg.sv -----
// Shared types and constants of the row convolver.
package vrc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 16;
  localparam int NUM_TAPS   = 7;
  localparam int TAP_IDX_W  = 3;
  localparam int HW_W       = 2;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VEC_W      = 3 * SAMPLE_W;

  localparam logic signed [TAP_W-1:0] TAP0_RESET = 16'sd16384;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KERN_HALF  = 3'd0,
    CFG_TAP_0      = 3'd1,
    CFG_TAP_1      = 3'd2,
    CFG_TAP_2      = 3'd3,
    CFG_TAP_3      = 3'd4,
    CFG_TAP_4      = 3'd5,
    CFG_TAP_5      = 3'd6,
    CFG_TAP_6      = 3'd7
  } cfg_reg_t;

  // The x component sits in the lowest bits of a packed vector.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
  } vec_t;

endpackage

// ----- hw/rtl/vrc_dot.sv -----
// One component's weighted sum over the window, rounded and saturated.
module vrc_dot
  import vrc_pkg::*;
#(
  parameter int WIN_DEPTH = 7
) (
  input  logic signed [SAMPLE_W-1:0] samp_i [WIN_DEPTH],
  input  logic signed [TAP_W-1:0]    coef_i [WIN_DEPTH],
  output logic signed [SAMPLE_W-1:0] res_o
);

  localparam int ACC_W = SAMPLE_W + TAP_W + $clog2(WIN_DEPTH) + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;

  always_comb begin
    logic signed [SAMPLE_W+TAP_W-1:0] prod;
    acc = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      prod = samp_i[k] * coef_i[k];
      acc  = acc + ACC_W'(prod);
    end
  end

  // Round half up, then drop the fraction bits of the taps.
  assign shifted = (acc + ROUND_HALF) >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      res_o = SAT_MAX[SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      res_o = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      res_o = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/vector_row_convolver_truncated.sv -----
// A result passes through the job register, then the output register, before it is taken.
// Throughput, unless the output stalls: one input word per cycle; a row-end word drains
// min(p, h)+1 output words, one per cycle, and the next input word is accepted together
// with the last of them.
// Reset (synchronous, rst_n low) clears the handshake state, the row position and the
// registers to half length 0, tap_0 1.0 and other taps 0; the sample window is not cleared.
module vector_row_convolver_truncated
  import vrc_pkg::*;
#(
  parameter int MAX_KERN_HALF  = 3,
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VEC_W-1:0]      in_tdata,   // comp_x, comp_y, comp_z
  input  logic                  in_tlast,   // row_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VEC_W-1:0]      out_tdata,  // out_x, out_y, out_z
  output logic                  out_tlast,  // row_last
  output logic                  out_tuser,  // run_last
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WIN_DEPTH = 2 * MAX_KERN_HALF + 1;
  localparam int PW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;

  logic [HW_W-1:0]          kern_half_r;
  logic signed [TAP_W-1:0]  taps_r [NUM_TAPS];
  vec_t                     window_r [WIN_DEPTH];
  logic [PW-1:0]            row_pos_r, row_pos_nxt;

  logic                     job_v_r, job_v_nxt;
  logic [HW_W-1:0]          job_d_r, job_d_nxt;
  logic                     job_last_r;
  logic [PW-1:0]            job_p_r;

  logic                     out_v_r, out_v_nxt;
  vec_t                     out_data_r;
  logic                     out_last_r;
  logic                     out_user_r;

  logic [HW_W-1:0]          h_eff;
  logic                     slot_free, job_final, emit, in_acc, p_ge_h;
  logic signed [TAP_W-1:0]  coef [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] samp_x [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] samp_y [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] samp_z [WIN_DEPTH];
  vec_t                     res;

  // Half widths beyond what the window holds are clamped.
  assign h_eff = (int'(kern_half_r) > MAX_KERN_HALF) ? HW_W'(MAX_KERN_HALF)
                                                     : kern_half_r;

  assign slot_free = !out_v_r || out_tready;
  assign job_final = !job_last_r || (job_d_r == '0);
  assign emit      = job_v_r && slot_free;
  assign in_tready = !job_v_r || (job_final && slot_free);
  assign in_acc    = in_tvalid && in_tready;
  assign p_ge_h    = int'(row_pos_r) >= int'(h_eff);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_half_r <= '0;
      for (int j = 0; j < NUM_TAPS; j++) begin
        taps_r[j] <= '0;
      end
      taps_r[0] <= TAP0_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_KERN_HALF) begin
        kern_half_r <= cfg_wdata[HW_W-1:0];
      end else if (cfg_addr inside {[CFG_TAP_0:CFG_TAP_6]}) begin
        taps_r[TAP_IDX_W'(cfg_addr - CFG_TAP_0)] <= cfg_wdata;
      end
    end
  end

  // Job control: a row-end word counts d down from min(p, h) to zero.
  always_comb begin
    job_v_nxt   = job_v_r;
    job_d_nxt   = job_d_r;
    row_pos_nxt = row_pos_r;
    if (in_acc) begin
      job_v_nxt = in_tlast || p_ge_h;
      job_d_nxt = (in_tlast && !p_ge_h) ? HW_W'(row_pos_r) : h_eff;
      if (in_tlast) begin
        row_pos_nxt = '0;
      end else if (int'(row_pos_r) < MAX_ROW_LENGTH - 1) begin
        row_pos_nxt = row_pos_r + 1'b1;
      end
    end else if (emit) begin
      if (job_final) begin
        job_v_nxt = 1'b0;
      end else begin
        job_d_nxt = job_d_r - 1'b1;
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r   <= 1'b0;
      row_pos_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      job_v_r   <= job_v_nxt;
      row_pos_r <= row_pos_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_d_r <= job_d_nxt;
    if (in_acc) begin
      job_last_r  <= in_tlast;
      job_p_r     <= row_pos_r;
      window_r[0] <= vec_t'(in_tdata);
      for (int k = 1; k < WIN_DEPTH; k++) begin
        window_r[k] <= window_r[k-1];
      end
    end
    if (emit) begin
      out_data_r <= res;
      out_last_r <= job_last_r && (job_d_r == '0);
      out_user_r <= job_final;
    end
  end

  // Window entry k (k words back from the newest) takes tap d+h-k; taps that
  // land before the row start or outside the kernel are zeroed together with
  // their samples, so an entry that was never written does not reach the sums.
  always_comb begin
    int s;
    int j;
    s = int'(job_d_r) + int'(h_eff);
    for (int k = 0; k < WIN_DEPTH; k++) begin
      j = s - k;
      if (j >= 0 && j <= 2 * int'(h_eff) && k <= int'(job_p_r)) begin
        coef[k]   = taps_r[j[TAP_IDX_W-1:0]];
        samp_x[k] = window_r[k].x;
        samp_y[k] = window_r[k].y;
        samp_z[k] = window_r[k].z;
      end else begin
        coef[k]   = '0;
        samp_x[k] = '0;
        samp_y[k] = '0;
        samp_z[k] = '0;
      end
    end
  end

  vrc_dot #(.WIN_DEPTH(WIN_DEPTH)) u_dot_x (.samp_i(samp_x), .coef_i(coef), .res_o(res.x));
  vrc_dot #(.WIN_DEPTH(WIN_DEPTH)) u_dot_y (.samp_i(samp_y), .coef_i(coef), .res_o(res.y));
  vrc_dot #(.WIN_DEPTH(WIN_DEPTH)) u_dot_z (.samp_i(samp_z), .coef_i(coef), .res_o(res.z));

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/vrc_checker.sv -----
// Port-level assertion checker for the row convolver, bound to the top level.
`include "vector_row_convolver_truncated_defines.svh"

module vrc_checker
  import vrc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [VEC_W-1:0]      out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // The row's final word is always the last word of its run.
  `VRC_ASSERT_IMPL(a_row_last_ends_run, out_tvalid && out_tlast, out_tuser,
                   "row_last word without run_last")

  // An accepted row-end word is always followed by a valid output word.
  `VRC_ASSERT_IMPL(a_row_end_drains, in_tvalid && in_tready && in_tlast, ##2 out_tvalid,
                   "row-end word produced no output")

  // A stalled output word holds.
  `VRC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser),
                   "stalled output word changed")

endmodule

bind vector_row_convolver_truncated vrc_checker u_vrc_checker (.*);
